### rtl/core/plob_pkg.sv
// Shared types, codes and helpers for the price level order book.
// Used by plob_cell and price_level_order_book; depends on nothing.
package plob_pkg;

  localparam int unsigned MaxLevelsDef = 64;
  localparam int unsigned MaxOrdersDef = 256;

  // Operation codes of an input word
  localparam logic [1:0] OpAdd    = 2'd0;
  localparam logic [1:0] OpCancel = 2'd1;

  // Status codes of a result word
  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StNotFound  = 3'd1;
  localparam logic [2:0] StDuplicate = 3'd2;
  localparam logic [2:0] StLevelFull = 3'd3;
  localparam logic [2:0] StOrderFull = 3'd4;

  // One resting order held by a cell
  typedef struct packed {
    logic        used;
    logic [31:0] id;
    logic [31:0] px;
    logic [31:0] qty;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_SORT
  } cell_cmd_e;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    cell_cmd_e   cmd;
    logic        phase;
    logic        side;
    logic [31:0] key_id;
    logic [31:0] key_px;
    entry_t      new_ent;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_CHECK,
    ST_APPLY,
    ST_RESP,
    ST_SORT
  } state_e;

  // True when price a ranks strictly ahead of price b on the given side
  function automatic logic better(input logic side, input logic [31:0] a,
                                  input logic [31:0] b);
    logic r;
    r = side ? (a < b) : (a > b);
    return r;
  endfunction

endpackage

### rtl/core/plob_cell.sv
// One cell of the sorted order chain: holds one order, shifts with neighbors.
// Depends on plob_pkg.
module plob_cell #(
  parameter int unsigned Idx  = 0,
  parameter int unsigned IdxW = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  plob_pkg::cell_ctl_t ctl_i,
  input  logic [IdxW-1:0]     hit_idx_i,
  input  plob_pkg::entry_t    left_i,
  input  logic                left_before_i,
  input  plob_pkg::entry_t    right_i,
  output plob_pkg::entry_t    ent_o,
  output logic                before_o,
  output logic                id_hit_o,
  output logic                px_hit_o
);
  import plob_pkg::*;

  localparam logic OddCell = 1'(Idx % 2);

  logic   used_q;
  entry_t pay_q;
  entry_t cur;
  entry_t nxt_d;

  assign cur      = '{used: used_q, id: pay_q.id, px: pay_q.px, qty: pay_q.qty};
  assign ent_o    = cur;
  assign before_o = !used_q || better(ctl_i.side, ctl_i.new_ent.px, pay_q.px);
  assign id_hit_o = used_q && (pay_q.id == ctl_i.key_id);
  assign px_hit_o = used_q && (pay_q.px == ctl_i.key_px);

  // Pick the next content: hold, take new word, or take a neighbor's
  always_comb begin
    nxt_d = cur;
    case (ctl_i.cmd)
      CELL_INSERT: begin
        if (before_o) nxt_d = left_before_i ? left_i : ctl_i.new_ent;
      end
      CELL_DELETE: begin
        if (IdxW'(Idx) >= hit_idx_i) nxt_d = right_i;
      end
      CELL_SORT: begin
        if (OddCell == ctl_i.phase) begin
          if (right_i.used && used_q && better(ctl_i.side, right_i.px, pay_q.px))
            nxt_d = right_i;
        end else begin
          if (left_i.used && used_q && better(ctl_i.side, pay_q.px, left_i.px))
            nxt_d = left_i;
        end
      end
      default: nxt_d = cur;
    endcase
  end

  // Occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else begin
      used_q <= nxt_d.used;
    end
  end

  // Order payload
  always_ff @(posedge clk_i) begin
    pay_q <= nxt_d;
  end

endmodule

### rtl/core/price_level_order_book.sv
// Top level of the price level order book: sequencer and chain of order cells.
// Depends on plob_pkg and plob_cell.

// Orders rest in a chain of MAX_ORDERS cells kept sorted by price priority
// (highest price first on the buy side, lowest first on the sell side) and by
// arrival within a price, so the best level's head order always sits in cell 0.
// Each word passes lookup, price check, chain update and result load in turn
// (ST_LOOK, ST_CHECK, ST_APPLY, ST_RESP); the result load waits while the
// previous result is stalled. A new word is accepted once the previous one is
// through the chain update and its result is loaded. A cfg_we_i write of the side
// re-sorts the chain by an odd-even exchange, during which no word is accepted.
// A level is a distinct resting price; at most MAX_LEVELS may rest at once.
module price_level_order_book
  import plob_pkg::*;
#(
  parameter int unsigned MAX_LEVELS = plob_pkg::MaxLevelsDef,
  parameter int unsigned MAX_ORDERS = plob_pkg::MaxOrdersDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [31:0] order_id_i,
  input  logic [31:0] price_ticks_i,
  input  logic [31:0] quantity_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic        best_valid_o,
  output logic [31:0] best_price_o,
  output logic [31:0] best_order_id_o,
  output logic [31:0] best_quantity_o
);

  localparam int unsigned IdxW = $clog2(MAX_ORDERS);
  localparam int unsigned LvlW = $clog2(MAX_LEVELS + 1);
  localparam int unsigned CntW = $clog2(MAX_ORDERS + 1);

  state_e state_q, state_d;
  logic side_q, sort_pend_q, phase_q;
  logic [CntW-1:0] sort_cnt_q;
  logic [LvlW-1:0] lvl_cnt_q;
  logic [1:0]  op_q;
  logic [31:0] id_q, px_q, qty_q, px_cap_q;
  logic any_id_q, any_px_q, others_q;
  logic [IdxW-1:0] hit_idx_q;
  logic [MAX_ORDERS-1:0] id_hit_q;
  logic [2:0] status_q;
  logic out_valid_q;
  logic [2:0]  st_out_q;
  logic        bv_q;
  logic [31:0] bp_q, bid_q, bqty_q;

  cell_ctl_t ctl;
  entry_t ent [MAX_ORDERS];
  logic [MAX_ORDERS-1:0] ins_here, id_hit, px_hit, used_vec;
  logic [IdxW-1:0] hit_idx_c;
  logic [31:0] px_cap_c;
  logic in_acc, resp_go, full, do_insert, do_delete;
  logic [2:0] status_c;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign resp_go = (state_q == ST_RESP) && !(out_valid_q && out_stall_i);
  assign full    = ent[MAX_ORDERS-1].used;

  // Chain of cells
  for (genvar i = 0; i < MAX_ORDERS; i++) begin : g_cell
    entry_t lft, rgt;
    logic   lft_before;
    if (i == 0) begin : g_first
      assign lft        = '0;
      assign lft_before = 1'b0;
    end else begin : g_mid
      assign lft        = ent[i-1];
      assign lft_before = ins_here[i-1];
    end
    if (i == MAX_ORDERS - 1) begin : g_last
      assign rgt = '0;
    end else begin : g_inner
      assign rgt = ent[i+1];
    end
    plob_cell #(.Idx(i), .IdxW(IdxW)) u_cell (
      .clk_i,
      .rst_ni,
      .ctl_i        (ctl),
      .hit_idx_i    (hit_idx_q),
      .left_i       (lft),
      .left_before_i(lft_before),
      .right_i      (rgt),
      .ent_o        (ent[i]),
      .before_o     (ins_here[i]),
      .id_hit_o     (id_hit[i]),
      .px_hit_o     (px_hit[i])
    );
    assign used_vec[i] = ent[i].used;
  end

  // Encode the id hit and grab its price (ids are unique, so at most one hit)
  always_comb begin
    hit_idx_c = '0;
    px_cap_c  = '0;
    for (int i = 0; i < MAX_ORDERS; i++) begin
      if (id_hit[i]) begin
        hit_idx_c = hit_idx_c | IdxW'(i);
        px_cap_c  = px_cap_c | ent[i].px;
      end
    end
  end

  // Decide the outcome of the held word
  always_comb begin
    status_c  = StOk;
    do_insert = 1'b0;
    do_delete = 1'b0;
    if (op_q == OpAdd) begin
      if (any_id_q) status_c = StDuplicate;
      else if (full) status_c = StOrderFull;
      else if (!any_px_q && (lvl_cnt_q == LvlW'(MAX_LEVELS))) status_c = StLevelFull;
      else do_insert = 1'b1;
    end else if (op_q == OpCancel) begin
      if (!any_id_q) status_c = StNotFound;
      else do_delete = 1'b1;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (sort_pend_q) state_d = ST_SORT;
        else if (in_acc) state_d = ST_LOOK;
      end
      ST_LOOK:  state_d = ST_CHECK;
      ST_CHECK: state_d = ST_APPLY;
      ST_APPLY: state_d = ST_RESP;
      ST_RESP: begin
        if (resp_go) state_d = ST_IDLE;
      end
      ST_SORT: begin
        if (sort_cnt_q == CntW'(MAX_ORDERS - 1)) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Cell control and handshake outputs
  always_comb begin
    ctl         = '0;
    ctl.cmd     = CELL_HOLD;
    ctl.phase   = phase_q;
    ctl.side    = side_q;
    ctl.key_id  = id_q;
    ctl.key_px  = (state_q == ST_CHECK) ? px_cap_q : px_q;
    ctl.new_ent = '{used: 1'b1, id: id_q, px: px_q, qty: qty_q};
    case (state_q)
      ST_APPLY: begin
        if (do_insert) ctl.cmd = CELL_INSERT;
        else if (do_delete) ctl.cmd = CELL_DELETE;
      end
      ST_SORT: ctl.cmd = CELL_SORT;
      default: ctl.cmd = CELL_HOLD;
    endcase
    in_stall_o = (state_q != ST_IDLE) || sort_pend_q;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      side_q      <= 1'b0;
      sort_pend_q <= 1'b0;
      phase_q     <= 1'b0;
      sort_cnt_q  <= '0;
      lvl_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        side_q      <= cfg_wdata_i;
        sort_pend_q <= 1'b1;
      end else if (state_q == ST_IDLE) begin
        sort_pend_q <= 1'b0;
      end
      if (state_q == ST_SORT) begin
        phase_q    <= !phase_q;
        sort_cnt_q <= sort_cnt_q + 1'b1;
      end else begin
        phase_q    <= 1'b0;
        sort_cnt_q <= '0;
      end
      if (state_q == ST_APPLY) begin
        if (do_insert && !any_px_q) lvl_cnt_q <= lvl_cnt_q + 1'b1;
        else if (do_delete && !others_q) lvl_cnt_q <= lvl_cnt_q - 1'b1;
      end
      if (resp_go) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Word and lookup registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= operation_i;
      id_q  <= order_id_i;
      px_q  <= price_ticks_i;
      qty_q <= quantity_i;
    end
    if (state_q == ST_LOOK) begin
      any_id_q  <= |id_hit;
      any_px_q  <= |px_hit;
      id_hit_q  <= id_hit;
      hit_idx_q <= hit_idx_c;
      px_cap_q  <= px_cap_c;
    end
    if (state_q == ST_CHECK) others_q <= |(px_hit & ~id_hit_q);
    if (state_q == ST_APPLY) status_q <= status_c;
    if (resp_go) begin
      st_out_q <= status_q;
      bv_q     <= ent[0].used;
      bp_q     <= ent[0].used ? ent[0].px  : 32'd0;
      bid_q    <= ent[0].used ? ent[0].id  : 32'd0;
      bqty_q   <= ent[0].used ? ent[0].qty : 32'd0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = st_out_q;
  assign best_valid_o    = bv_q;
  assign best_price_o    = bp_q;
  assign best_order_id_o = bid_q;
  assign best_quantity_o = bqty_q;

`ifndef SYNTHESIS
  a_lvl_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_cnt_q <= LvlW'(MAX_LEVELS))
    else $error("level count above table size");

  a_compact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((used_vec + 1'b1) & used_vec) == '0)
    else $error("order chain has a gap");

  a_resp_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp_go |=> out_valid_q)
    else $error("result word not presented");

  a_empty_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lvl_cnt_q == '0) |-> !ent[0].used)
    else $error("orders rest with no level counted");
`endif

endmodule
